@@ rtl/fp16_sum_of_squares_fp32_top_defines.svh @@
// Assertion macros used by the top-level RTL file of the sum-of-squares block.
`ifndef FP16_SUM_OF_SQUARES_FP32_TOP_DEFINES_SVH
`define FP16_SUM_OF_SQUARES_FP32_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check that a condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("fsos assertion failed");
// Check that a trigger implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, trig, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cons)) \
		else $error("fsos assertion failed");
`else
`define ASSERT_ALWAYS(label, cond)
`define ASSERT_IMPLIES(label, trig, cons)
`endif

`endif

@@ rtl/fsos_pkg.sv @@
// Package with constants and types of the sum-of-squares block.
`timescale 1ns / 1ps
`default_nettype none

package fsos_pkg;

	localparam int BLOCK_SIZE = 256;
	localparam int ADDR_W     = $clog2(BLOCK_SIZE);
	localparam int FILL_W     = ADDR_W + 1;

	localparam logic [31:0] FP_QNAN = 32'h7FC00000;
	localparam logic [31:0] FP_INF  = 32'h7F800000;
	localparam logic [31:0] FP_ZERO = 32'h00000000;

	typedef enum logic [2:0] {
		ST_FILL,
		ST_TREE,
		ST_TOTAL,
		ST_WAIT,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

@@ rtl/fsos_ram.sv @@
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module fsos_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one entry, read two through registered outputs
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

`default_nettype wire

@@ rtl/fp16_sum_of_squares_fp32_top.sv @@
// Top level: fp16 squares gathered in blocks, tree-reduced, accumulated in fp32.
//
// channel  signals                         direction  accepted when
// value    value_valid value_stall         in         value_valid && !value_stall
//          value_bits last
// sum      sum_valid sum_stall sum_bits    out        sum_valid && !sum_stall
//
// Each accepted item is squared and written to the block memory. A full block or a last
// item stops intake while one shared two-stage adder reduces the block level by level,
// each tree level with a smaller stride than the last, then adds the block to the running
// total and, after a last item, loads the result into the output register.
// Reset clears the controller and the running total; memory contents need none.
// A waiting result holds in the output register while the next vector fills.
`timescale 1ns / 1ps
`default_nettype none
`include "fp16_sum_of_squares_fp32_top_defines.svh"

module fp16_sum_of_squares_fp32_top import fsos_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        value_valid,
	output logic             value_stall,
	input  wire logic [15:0] value_bits,
	input  wire logic        last,
	output logic             sum_valid,
	input  wire logic        sum_stall,
	output logic      [31:0] sum_bits
);

	// Exact square of a widened half value as fp32 bits
	function automatic logic [31:0] square_half(input logic [15:0] h);
		logic [4:0]  ex;
		logic [9:0]  man;
		logic [10:0] m11;
		logic [9:0]  e32;
		logic [3:0]  pos;
		logic [3:0]  sh;
		logic [21:0] p;
		logic [9:0]  es;
		logic [22:0] frac;
		logic [31:0] res;
		ex  = h[14:10];
		man = h[9:0];
		pos = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (man[i]) begin
				pos = 4'(i);
			end
		end
		sh = 4'd10 - pos;
		if (ex != 5'd0) begin
			m11 = {1'b1, man};
			e32 = {5'd0, ex} + 10'd112;
		end else begin
			m11 = {1'b0, man} << sh;
			e32 = 10'd113 - {6'd0, sh};
		end
		p = {11'd0, m11} * {11'd0, m11};
		if (p[21]) begin
			es   = (e32 << 1) - 10'd126;
			frac = {p[20:0], 2'b00};
		end else begin
			es   = (e32 << 1) - 10'd127;
			frac = {p[19:0], 3'b000};
		end
		if (ex == 5'h1F) begin
			res = (man != 10'd0) ? FP_QNAN : FP_INF;
		end else if (ex == 5'd0 && man == 10'd0) begin
			res = FP_ZERO;
		end else begin
			res = {1'b0, es[7:0], frac};
		end
		return res;
	endfunction

	state_t state_q, state_d;

	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] m_q;
	logic [ADDR_W-1:0] t_q;
	logic              last_q;
	logic [31:0]       total_q;
	logic              sum_valid_q;
	logic [31:0]       sum_bits_q;

	logic              accept;
	logic              issue;
	logic              fin_issue;
	logic              level_done;
	logic              load_out;
	logic [FILL_W-1:0] stride;
	logic [FILL_W:0]   idx_b;
	logic              level0;

	logic              v_s1, za_s1, zb_s1, fin_s1;
	logic [ADDR_W-1:0] dst_s1;
	logic              v_s2, fin_s2, nan_s2, inf_s2;
	logic [ADDR_W-1:0] dst_s2;
	logic [7:0]        e_s2;
	logic [26:0]       big_s2, sml_s2;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr_a, ram_raddr_b;
	logic [31:0]       ram_wdata, rd_a, rd_b;
	logic [31:0]       add_res;

	assign accept = value_valid && !value_stall;
	assign stride = FILL_W'(({1'b0, m_q} + (FILL_W+1)'(1)) >> 1);
	assign idx_b  = {2'b00, t_q} + {1'b0, stride};
	assign level0 = (m_q == FILL_W'(BLOCK_SIZE));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_FILL: begin
				if (accept && (last || fill_q + FILL_W'(1) == FILL_W'(BLOCK_SIZE))) begin
					state_d = ST_TREE;
				end
			end
			ST_TREE: begin
				if (m_q == FILL_W'(1)) begin
					state_d = ST_TOTAL;
				end
			end
			ST_TOTAL: state_d = ST_WAIT;
			ST_WAIT: begin
				if (v_s2 && fin_s2) begin
					state_d = last_q ? ST_OUT : ST_FILL;
				end
			end
			ST_OUT: begin
				if (load_out) begin
					state_d = ST_FILL;
				end
			end
			default: state_d = ST_FILL;
		endcase
	end

	// Controller outputs
	always_comb begin
		value_stall = (state_q != ST_FILL);
		issue       = (state_q == ST_TREE) && (m_q != FILL_W'(1))
		              && (idx_b < {1'b0, m_q});
		level_done  = (state_q == ST_TREE) && (m_q != FILL_W'(1)) && !issue
		              && !v_s1 && !v_s2;
		fin_issue   = (state_q == ST_TOTAL);
		load_out    = (state_q == ST_OUT) && (!sum_valid_q || !sum_stall);
	end

	// Share the write port between intake and tree write-back
	always_comb begin
		ram_we      = accept || (v_s2 && !fin_s2);
		ram_waddr   = accept ? fill_q[ADDR_W-1:0] : dst_s2;
		ram_wdata   = accept ? square_half(value_bits) : add_res;
		ram_raddr_a = fin_issue ? '0 : t_q;
		ram_raddr_b = idx_b[ADDR_W-1:0];
	end

	fsos_ram #(
		.WIDTH (32),
		.DEPTH (BLOCK_SIZE)
	) u_block_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (ram_raddr_a),
		.raddr_b (ram_raddr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			fill_q      <= '0;
			m_q         <= '0;
			t_q         <= '0;
			last_q      <= 1'b0;
			total_q     <= FP_ZERO;
			sum_valid_q <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				fill_q <= fill_q + FILL_W'(1);
				last_q <= last;
				m_q    <= FILL_W'(BLOCK_SIZE);
				t_q    <= '0;
			end
			if (issue) begin
				t_q <= t_q + ADDR_W'(1);
			end
			if (level_done) begin
				m_q <= stride;
				t_q <= '0;
			end
			if (v_s2 && fin_s2) begin
				total_q <= add_res;
				fill_q  <= '0;
			end
			if (load_out) begin
				sum_valid_q <= 1'b1;
				total_q     <= FP_ZERO;
			end else if (sum_valid_q && !sum_stall) begin
				sum_valid_q <= 1'b0;
			end
			v_s1 <= issue || fin_issue;
			v_s2 <= v_s1;
		end
	end

	// Hold the result for the output channel
	always_ff @(posedge clk) begin
		if (load_out) begin
			sum_bits_q <= (total_q[30:23] == 8'hFF && total_q[22:0] != 23'd0)
			              ? FP_QNAN : total_q;
		end
	end

	assign sum_valid = sum_valid_q;
	assign sum_bits  = sum_bits_q;

	// Track the issued addition while the RAM read completes
	always_ff @(posedge clk) begin
		dst_s1 <= t_q;
		fin_s1 <= fin_issue;
		za_s1  <= level0 && ({1'b0, t_q} >= fill_q);
		zb_s1  <= level0 && (idx_b >= {1'b0, fill_q});
	end

	// Adder stage one: pick operands, align the smaller one
	logic [31:0] opa, opb, big, sml;
	logic [7:0]  eb, es1, d;
	logic [23:0] mb, ms;
	logic [26:0] sext, smask;
	logic        a_nan, b_nan, a_inf, b_inf, far;

	always_comb begin
		opa   = fin_s1 ? total_q : (za_s1 ? FP_ZERO : rd_a);
		opb   = fin_s1 ? rd_a : (zb_s1 ? FP_ZERO : rd_b);
		a_nan = (opa[30:23] == 8'hFF) && (opa[22:0] != 23'd0);
		b_nan = (opb[30:23] == 8'hFF) && (opb[22:0] != 23'd0);
		a_inf = (opa[30:23] == 8'hFF) && (opa[22:0] == 23'd0);
		b_inf = (opb[30:23] == 8'hFF) && (opb[22:0] == 23'd0);
		big   = (opa[30:0] >= opb[30:0]) ? opa : opb;
		sml   = (opa[30:0] >= opb[30:0]) ? opb : opa;
		eb    = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
		es1   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
		mb    = {big[30:23] != 8'd0, big[22:0]};
		ms    = {sml[30:23] != 8'd0, sml[22:0]};
		d     = eb - es1;
		far   = (d >= 8'd27);
		smask = (27'd1 << d[4:0]) - 27'd1;
		sext  = {ms, 3'b000};
	end

	always_ff @(posedge clk) begin
		v_s2_payload: begin
			dst_s2 <= dst_s1;
			fin_s2 <= fin_s1;
			nan_s2 <= a_nan || b_nan;
			inf_s2 <= a_inf || b_inf;
			e_s2   <= eb;
			big_s2 <= {mb, 3'b000};
			sml_s2 <= far ? {26'd0, ms != 24'd0}
			              : ((sext >> d[4:0]) | {26'd0, (sext & smask) != 27'd0});
		end
	end

	// Adder stage two: add, normalize by one place, round to nearest even
	logic [27:0] sum28;
	logic [23:0] mn;
	logic [24:0] mr;
	logic        g, st, up;
	logic [9:0]  e10;
	logic [7:0]  ef;

	always_comb begin
		sum28 = {1'b0, big_s2} + {1'b0, sml_s2};
		if (sum28[27]) begin
			mn  = sum28[27:4];
			g   = sum28[3];
			st  = (sum28[2:0] != 3'd0);
			e10 = {2'd0, e_s2} + 10'd1;
		end else begin
			mn  = sum28[26:3];
			g   = sum28[2];
			st  = (sum28[1:0] != 2'd0);
			e10 = {2'd0, e_s2};
		end
		up = g && (st || mn[0]);
		mr = {1'b0, mn} + {24'd0, up};
		if (mr[24]) begin
			mr  = {1'b0, 24'h800000};
			e10 = e10 + 10'd1;
		end
		ef = mr[23] ? e10[7:0] : 8'd0;
		if (nan_s2) begin
			add_res = FP_QNAN;
		end else if (inf_s2 || e10 >= 10'd255) begin
			add_res = FP_INF;
		end else begin
			add_res = {1'b0, ef, mr[22:0]};
		end
	end

	`ASSERT_IMPLIES(a_wb_no_intake, v_s2, value_stall)
	`ASSERT_ALWAYS(a_fill_range, fill_q <= FILL_W'(BLOCK_SIZE))
	`ASSERT_IMPLIES(a_total_in_wait, v_s1 && fin_s1, state_q == ST_WAIT)
	`ASSERT_IMPLIES(a_out_from_out, $rose(sum_valid_q), $past(state_q == ST_OUT))

endmodule

`default_nettype wire
